FILE: src/bcdte_pkg.sv
`timescale 1ns / 1ps

package bcdte_pkg;

    // Item kinds on the command channel
    typedef enum logic [1:0] {
        KIND_MODE = 2'd0,
        KIND_UP   = 2'd1,
        KIND_DOWN = 2'd2,
        KIND_LOAD = 2'd3
    } kind_t;

    // Field selection codes
    localparam logic [2:0] FIELD_NONE   = 3'd0;
    localparam logic [2:0] FIELD_HOUR   = 3'd1;
    localparam logic [2:0] FIELD_MINUTE = 3'd2;
    localparam logic [2:0] FIELD_SECOND = 3'd3;
    localparam logic [2:0] FIELD_DATE   = 3'd4;
    localparam logic [2:0] FIELD_MONTH  = 3'd5;
    localparam logic [2:0] FIELD_YEAR   = 3'd6;

    // Upper limits for the up button
    localparam logic [7:0] TOP_SEC_MIN = 8'h59;
    localparam logic [7:0] TOP_HOUR    = 8'h23;
    localparam logic [7:0] TOP_DATE    = 8'h31;
    localparam logic [7:0] TOP_MONTH   = 8'h12;
    localparam logic [7:0] TOP_YEAR    = 8'h99;

    // Lower limits for the down button
    localparam logic [7:0] BOTTOM_TIME = 8'h00;
    localparam logic [7:0] BOTTOM_CAL  = 8'h01;

    // Nibble codes handled by the fix
    localparam logic [3:0] NIBBLE_TEN     = 4'hA;
    localparam logic [3:0] NIBBLE_FIFTEEN = 4'hF;
    localparam logic [7:0] BCD_ADJUST     = 8'h06;

    // Reset values of the time registers
    localparam logic [7:0] RESET_SECOND = 8'h00;
    localparam logic [7:0] RESET_MINUTE = 8'h00;
    localparam logic [7:0] RESET_HOUR   = 8'h00;
    localparam logic [7:0] RESET_DATE   = 8'h18;
    localparam logic [7:0] RESET_MONTH  = 8'h04;
    localparam logic [7:0] RESET_YEAR   = 8'h23;

    // Pull a low nibble of ten up to the next decade, and fold fifteen back down
    function automatic logic [7:0] nibble_fix(input logic [7:0] v);
        logic [7:0] t;
        t = v;
        if (t[3:0] == NIBBLE_TEN) begin
            t = t + BCD_ADJUST;
        end
        if (t[3:0] == NIBBLE_FIFTEEN) begin
            t = t - BCD_ADJUST;
        end
        return t;
    endfunction

    // Move one field by one within its limits
    function automatic logic [7:0] bump(input logic [7:0] v, input logic up,
                                        input logic [7:0] top, input logic [7:0] bottom);
        logic [7:0] t;
        t = v;
        if (up) begin
            if (v < top) begin
                t = v + 8'd1;
            end
        end else begin
            if (v > bottom) begin
                t = v - 8'd1;
            end
        end
        return t;
    endfunction

endpackage

FILE: src/bcdte_cmd_if.sv
`timescale 1ns / 1ps

interface bcdte_cmd_if;
    import bcdte_pkg::*;

    logic       valid;
    logic       ready;
    kind_t      kind;
    logic [7:0] load_second;
    logic [7:0] load_minute;
    logic [7:0] load_hour;
    logic [7:0] load_date;
    logic [7:0] load_month;
    logic [7:0] load_year;

    modport source (
        output valid, kind, load_second, load_minute, load_hour,
               load_date, load_month, load_year,
        input  ready
    );

    modport sink (
        input  valid, kind, load_second, load_minute, load_hour,
               load_date, load_month, load_year,
        output ready
    );
endinterface

FILE: src/bcdte_res_if.sv
`timescale 1ns / 1ps

interface bcdte_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] edit_field;
    logic [7:0] out_second;
    logic [7:0] out_minute;
    logic [7:0] out_hour;
    logic [7:0] out_date;
    logic [7:0] out_month;
    logic [7:0] out_year;
    logic       write_strobe;

    modport source (
        output valid, edit_field, out_second, out_minute, out_hour,
               out_date, out_month, out_year, write_strobe,
        input  ready
    );

    modport sink (
        input  valid, edit_field, out_second, out_minute, out_hour,
               out_date, out_month, out_year, write_strobe,
        output ready
    );
endinterface

FILE: src/bcd_time_set_editor_top.sv
`timescale 1ns / 1ps

// Channel  Modport  Word
// cmd      sink     kind, load_second .. load_year
// res      source   edit_field, out_second .. out_year, write_strobe
//
// One word per cycle sustained while res takes each result. A word passes the
// command register, then the state update that fills the result register.
// The edit state and the result register are written at the same edge, so the
// next word sees the updated time. Reset (rst_n low) clears selection to none and
// loads the default time. A stall on res holds the result register, then the
// command register, and drops cmd.ready only when both are full.
module bcd_time_set_editor_top
    import bcdte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bcdte_cmd_if.sink   cmd,
    bcdte_res_if.source res
);

    // Command register
    logic       cmd_valid_reg;
    kind_t      kind_reg;
    logic [7:0] ld_sec_reg, ld_min_reg, ld_hour_reg;
    logic [7:0] ld_date_reg, ld_month_reg, ld_year_reg;

    // Edit state
    logic [2:0] sel_reg, sel_next;
    logic [7:0] sec_reg, sec_next;
    logic [7:0] min_reg, min_next;
    logic [7:0] hour_reg, hour_next;
    logic [7:0] date_reg, date_next;
    logic [7:0] month_reg, month_next;
    logic [7:0] year_reg, year_next;
    logic       strobe_next;

    // Result register
    logic       res_valid_reg;
    logic       strobe_reg;

    logic res_free;
    logic advance;

    assign res_free  = !res_valid_reg || res.ready;
    assign advance   = cmd_valid_reg && res_free;
    assign cmd.ready = !cmd_valid_reg || res_free;

    // Capture a command word
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cmd_valid_reg <= 1'b0;
        end else if (cmd.ready) begin
            cmd_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.ready && cmd.valid) begin
            kind_reg     <= cmd.kind;
            ld_sec_reg   <= cmd.load_second;
            ld_min_reg   <= cmd.load_minute;
            ld_hour_reg  <= cmd.load_hour;
            ld_date_reg  <= cmd.load_date;
            ld_month_reg <= cmd.load_month;
            ld_year_reg  <= cmd.load_year;
        end
    end

    // Work out the next edit state
    always_comb begin
        logic up;
        logic [7:0] s, m, h, d, mo, y;
        up          = (kind_reg == KIND_UP);
        sel_next    = sel_reg;
        s           = sec_reg;
        m           = min_reg;
        h           = hour_reg;
        d           = date_reg;
        mo          = month_reg;
        y           = year_reg;
        sec_next    = sec_reg;
        min_next    = min_reg;
        hour_next   = hour_reg;
        date_next   = date_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        strobe_next = 1'b0;
        unique case (kind_reg)
            KIND_MODE: begin
                // advance the cursor, wrap past year to none
                if (sel_reg >= FIELD_YEAR) begin
                    sel_next = FIELD_NONE;
                end else begin
                    sel_next = sel_reg + 3'd1;
                end
            end
            KIND_UP, KIND_DOWN: begin
                unique case (sel_reg)
                    FIELD_HOUR:   h  = bump(hour_reg, up, TOP_HOUR, BOTTOM_TIME);
                    FIELD_MINUTE: m  = bump(min_reg, up, TOP_SEC_MIN, BOTTOM_TIME);
                    FIELD_SECOND: s  = bump(sec_reg, up, TOP_SEC_MIN, BOTTOM_TIME);
                    FIELD_DATE:   d  = bump(date_reg, up, TOP_DATE, BOTTOM_CAL);
                    FIELD_MONTH:  mo = bump(month_reg, up, TOP_MONTH, BOTTOM_CAL);
                    FIELD_YEAR:   y  = bump(year_reg, up, TOP_YEAR, BOTTOM_CAL);
                    default: ;
                endcase
                // clean up every field after the move
                sec_next    = nibble_fix(s);
                min_next    = nibble_fix(m);
                hour_next   = nibble_fix(h);
                date_next   = nibble_fix(d);
                month_next  = nibble_fix(mo);
                year_next   = nibble_fix(y);
                strobe_next = 1'b1;
            end
            KIND_LOAD: begin
                sec_next   = ld_sec_reg;
                min_next   = ld_min_reg;
                hour_next  = ld_hour_reg;
                date_next  = ld_date_reg;
                month_next = ld_month_reg;
                year_next  = ld_year_reg;
            end
            default: ;
        endcase
    end

    // Commit the edit state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sel_reg   <= FIELD_NONE;
            sec_reg   <= RESET_SECOND;
            min_reg   <= RESET_MINUTE;
            hour_reg  <= RESET_HOUR;
            date_reg  <= RESET_DATE;
            month_reg <= RESET_MONTH;
            year_reg  <= RESET_YEAR;
        end else if (advance) begin
            sel_reg   <= sel_next;
            sec_reg   <= sec_next;
            min_reg   <= min_next;
            hour_reg  <= hour_next;
            date_reg  <= date_next;
            month_reg <= month_next;
            year_reg  <= year_next;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end else if (res_free) begin
            res_valid_reg <= cmd_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            strobe_reg <= strobe_next;
        end
    end

    // The time registers double as the result payload
    assign res.valid        = res_valid_reg;
    assign res.edit_field   = sel_reg;
    assign res.out_second   = sec_reg;
    assign res.out_minute   = min_reg;
    assign res.out_hour     = hour_reg;
    assign res.out_date     = date_reg;
    assign res.out_month    = month_reg;
    assign res.out_year     = year_reg;
    assign res.write_strobe = strobe_reg;

endmodule
